/* hdl/pba_pkg.sv */
// pba_pkg: shared types and constants of the port bitmap allocator
// holds request and status codes, register indexes, the control state type
// and the word scan result; depends on nothing
package pba_pkg;

  localparam int PORT_W    = 16;  // width of port number fields
  localparam int PROTO_W   = 2;   // width of the protocol field
  localparam int CMP_W     = 17;  // compare width for range checks
  localparam int MAP_WORD  = 64;  // bitmap word width
  localparam int BIT_IDX_W = 6;   // bit index inside a bitmap word
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 16;

  localparam logic [PORT_W-1:0] PORT_LOW_RESET  = 16'd4096;
  localparam logic [PORT_W-1:0] PORT_HIGH_RESET = 16'd65535;

  localparam logic [CFG_IDX_W-1:0] REG_PORT_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PORT_HIGH = 1'b1;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_MARK  = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MARK_WR,
    S_SCAN,
    S_RESP
  } pba_state_t;

  typedef struct packed {
    logic                 hit;
    logic [BIT_IDX_W-1:0] bit_idx;
  } scan_res_t;

endpackage

/* hdl/pba_map_ram.sv */
// pba_map_ram: usage bitmap storage, one 64-bit word per row
// one write port and one read port with registered read data; uses pba_pkg
module pba_map_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [pba_pkg::MAP_WORD-1:0]  wdata,
  input  logic                          re,
  input  logic [AW-1:0]                 raddr,
  output logic [pba_pkg::MAP_WORD-1:0]  rdata
);
  import pba_pkg::*;

  logic [MAP_WORD-1:0] mem [DEPTH];
  logic [MAP_WORD-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/pba_scan.sv */
// pba_scan: examines one bitmap word against a port window
// masks ports outside [lo_bound, hi_bound] and finds the lowest free bit; uses pba_pkg
module pba_scan #(
  parameter int PORT_BITS = 16
) (
  input  logic [PORT_BITS-7:0]          scan_word,
  input  logic [PORT_BITS-1:0]          lo_bound,
  input  logic [PORT_BITS-1:0]          hi_bound,
  input  logic [pba_pkg::MAP_WORD-1:0]  rdata,
  output pba_pkg::scan_res_t            res
);
  import pba_pkg::*;

  localparam int WW = PORT_BITS - BIT_IDX_W;

  logic [WW-1:0]       lo_word;
  logic [WW-1:0]       hi_word;
  logic [MAP_WORD-1:0] lo_mask;
  logic [MAP_WORD-1:0] hi_mask;
  logic [MAP_WORD-1:0] free_bits;

  assign lo_word = lo_bound[PORT_BITS-1:BIT_IDX_W];
  assign hi_word = hi_bound[PORT_BITS-1:BIT_IDX_W];

  always_comb begin
    if (scan_word > lo_word) begin
      lo_mask = '1;
    end else if (scan_word == lo_word) begin
      lo_mask = {MAP_WORD{1'b1}} << lo_bound[BIT_IDX_W-1:0];
    end else begin
      lo_mask = '0;
    end
    if (scan_word < hi_word) begin
      hi_mask = '1;
    end else if (scan_word == hi_word) begin
      hi_mask = {MAP_WORD{1'b1}} >> (6'd63 - hi_bound[BIT_IDX_W-1:0]);
    end else begin
      hi_mask = '0;
    end
  end

  assign free_bits = ~rdata & lo_mask & hi_mask;

  // lowest set bit wins
  always_comb begin
    res.hit     = |free_bits;
    res.bit_idx = '0;
    for (int i = MAP_WORD - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        res.bit_idx = BIT_IDX_W'(i);
      end
    end
  end

endmodule

/* hdl/port_bitmap_allocator.sv */
// port_bitmap_allocator: next-fit port allocator, one bitmap per protocol class
// mark: read the map word, write it back, give the result; allocate: read k
// bitmap words, one word per cycle from the single map read port, k up to
// 2^(PORT_BITS-6) + 1; one item at a time; the next is taken on hand-off of
// the result; reset: rover and registers reset at once, then a pass over the map
// clears all NUM_PROTOCOLS * 2^(PORT_BITS-6) rows (4096 by default), stall high
module port_bitmap_allocator #(
  parameter int PORT_BITS     = 16,
  parameter int NUM_PROTOCOLS = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pba_pkg::CFG_DAT_W-1:0]   cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_req_type,
  input  logic [pba_pkg::PROTO_W-1:0]     in_protocol,
  input  logic [pba_pkg::PORT_W-1:0]      in_port_number,
  input  logic                            in_in_use,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [pba_pkg::PORT_W-1:0]      out_port_result,
  output logic                            out_status
);
  import pba_pkg::*;

  localparam int PB       = PORT_BITS;
  localparam int WW       = PORT_BITS - BIT_IDX_W;
  localparam int PIW      = (NUM_PROTOCOLS > 1) ? $clog2(NUM_PROTOCOLS) : 1;
  localparam int AW       = PIW + WW;
  localparam int DEPTH    = NUM_PROTOCOLS << WW;
  localparam int RW       = PORT_BITS + 1;
  localparam int PORT_MAX = (1 << PORT_BITS) - 1;

  pba_state_t state_r, state_nxt;

  logic [PORT_W-1:0]    port_low_r;
  logic [PORT_W-1:0]    port_high_r;
  logic [RW-1:0]        rover_r [NUM_PROTOCOLS];

  logic [PIW-1:0]       proto_r, proto_nxt;
  logic                 alloc_r, alloc_nxt;
  logic [BIT_IDX_W-1:0] mark_bit_r, mark_bit_nxt;
  logic                 mark_use_r, mark_use_nxt;
  logic [PB-1:0]        lo_r, lo_nxt;
  logic [PB-1:0]        hi_r, hi_nxt;
  logic [PB-1:0]        cur_r, cur_nxt;
  logic [PB-1:0]        cur_m1_r, cur_m1_nxt;
  logic                 wrap_r, wrap_nxt;
  logic [WW-1:0]        iss_word_r, iss_word_nxt;
  logic                 iss_pass_r, iss_pass_nxt;
  logic                 iss_done_r, iss_done_nxt;
  logic                 tag_valid_r, tag_valid_nxt;
  logic [WW-1:0]        tag_word_r, tag_word_nxt;
  logic                 tag_pass_r, tag_pass_nxt;
  logic                 tag_last_r, tag_last_nxt;
  logic [PB-1:0]        res_port_r, res_port_nxt;
  logic                 res_status_r, res_status_nxt;
  logic [AW-1:0]        clr_addr_r, clr_addr_nxt;

  logic                 out_valid_r;
  logic [PORT_W-1:0]    out_port_r;
  logic                 out_status_r;

  logic                 rover_we;
  logic [PIW-1:0]       rover_widx;
  logic [RW-1:0]        rover_wval;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [MAP_WORD-1:0]  mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic [MAP_WORD-1:0]  mem_rdata;

  logic                 in_accept;
  logic                 res_load;
  logic [PIW-1:0]       in_pidx;
  logic                 proto_present;
  logic [PB-1:0]        hi_eff;
  logic [CMP_W-1:0]     lo_ext;
  logic [CMP_W-1:0]     hi_ext;
  logic [CMP_W-1:0]     rov_ext;
  logic [CMP_W-1:0]     cur_sel;
  logic                 range_ok;
  logic                 iss_last;
  logic [PB-1:0]        scan_lo;
  logic [PB-1:0]        scan_hi;
  logic [PB-1:0]        hit_port;
  scan_res_t            scan_res;

  pba_map_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // window of the word coming back: pass 0 is [cur, hi], pass 1 is [lo, cur - 1]
  assign scan_lo = tag_pass_r ? lo_r : cur_r;
  assign scan_hi = tag_pass_r ? cur_m1_r : hi_r;

  pba_scan #(
    .PORT_BITS (PORT_BITS)
  ) u_scan (
    .scan_word (tag_word_r),
    .lo_bound  (scan_lo),
    .hi_bound  (scan_hi),
    .rdata     (mem_rdata),
    .res       (scan_res)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign res_load  = (state_r == S_RESP) && (!out_valid_r || !out_stall);

  assign in_pidx       = PIW'(in_protocol);
  assign proto_present = (4'(in_protocol) < 4'(NUM_PROTOCOLS));

  // start of an allocation: clip high, pick the search start from the rover
  always_comb begin
    if ({1'b0, port_high_r} > CMP_W'(PORT_MAX)) begin
      hi_eff = PB'(PORT_MAX);
    end else begin
      hi_eff = port_high_r[PB-1:0];
    end
    lo_ext   = CMP_W'(port_low_r);
    hi_ext   = CMP_W'(hi_eff);
    range_ok = (lo_ext <= hi_ext);
    rov_ext  = CMP_W'(rover_r[in_pidx]);
    if (rov_ext == '0 || rov_ext < lo_ext || rov_ext > hi_ext) begin
      cur_sel = lo_ext;
    end else begin
      cur_sel = rov_ext;
    end
  end

  assign iss_last = iss_pass_r ? (iss_word_r == cur_m1_r[PB-1:BIT_IDX_W])
                               : (iss_word_r == hi_r[PB-1:BIT_IDX_W] && !wrap_r);
  assign hit_port = {tag_word_r, scan_res.bit_idx};

  always_comb begin
    state_nxt      = state_r;
    proto_nxt      = proto_r;
    alloc_nxt      = alloc_r;
    mark_bit_nxt   = mark_bit_r;
    mark_use_nxt   = mark_use_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    cur_nxt        = cur_r;
    cur_m1_nxt     = cur_m1_r;
    wrap_nxt       = wrap_r;
    iss_word_nxt   = iss_word_r;
    iss_pass_nxt   = iss_pass_r;
    iss_done_nxt   = iss_done_r;
    tag_valid_nxt  = 1'b0;
    tag_word_nxt   = tag_word_r;
    tag_pass_nxt   = tag_pass_r;
    tag_last_nxt   = tag_last_r;
    res_port_nxt   = res_port_r;
    res_status_nxt = res_status_r;
    clr_addr_nxt   = clr_addr_r;
    rover_we       = 1'b0;
    rover_widx     = proto_r;
    rover_wval     = '0;
    mem_we         = 1'b0;
    mem_waddr      = {proto_r, tag_word_r};
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = {proto_r, iss_word_r};

    unique case (state_r)
      S_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        mem_wdata    = '0;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_accept) begin
          proto_nxt      = in_pidx;
          alloc_nxt      = (in_req_type == REQ_ALLOC);
          res_port_nxt   = '0;
          res_status_nxt = STATUS_OK;
          if (!proto_present) begin
            res_status_nxt = STATUS_FAIL;
            state_nxt      = S_RESP;
          end else if (in_req_type == REQ_MARK) begin
            mem_re       = 1'b1;
            mem_raddr    = {in_pidx, in_port_number[PB-1:BIT_IDX_W]};
            iss_word_nxt = in_port_number[PB-1:BIT_IDX_W];
            mark_bit_nxt = in_port_number[BIT_IDX_W-1:0];
            mark_use_nxt = in_in_use;
            state_nxt    = S_MARK_WR;
          end else if (!range_ok) begin
            rover_we       = 1'b1;
            rover_widx     = in_pidx;
            rover_wval     = '0;
            res_status_nxt = STATUS_FAIL;
            state_nxt      = S_RESP;
          end else begin
            lo_nxt       = PB'(lo_ext);
            hi_nxt       = hi_eff;
            cur_nxt      = PB'(cur_sel);
            cur_m1_nxt   = PB'(cur_sel - CMP_W'(1));
            wrap_nxt     = (cur_sel > lo_ext);
            iss_word_nxt = cur_sel[PB-1:BIT_IDX_W];
            iss_pass_nxt = 1'b0;
            iss_done_nxt = 1'b0;
            state_nxt    = S_SCAN;
          end
        end
      end

      S_MARK_WR: begin
        mem_we    = 1'b1;
        mem_waddr = {proto_r, iss_word_r};
        if (mark_use_r) begin
          mem_wdata = mem_rdata | (MAP_WORD'(1) << mark_bit_r);
        end else begin
          mem_wdata = mem_rdata & ~(MAP_WORD'(1) << mark_bit_r);
        end
        state_nxt = S_RESP;
      end

      S_SCAN: begin
        // issue side: one word read per cycle along the circular order
        if (!iss_done_r) begin
          mem_re        = 1'b1;
          tag_valid_nxt = 1'b1;
          tag_word_nxt  = iss_word_r;
          tag_pass_nxt  = iss_pass_r;
          tag_last_nxt  = iss_last;
          if (iss_last) begin
            iss_done_nxt = 1'b1;
          end else if (!iss_pass_r && iss_word_r == hi_r[PB-1:BIT_IDX_W]) begin
            iss_pass_nxt = 1'b1;
            iss_word_nxt = lo_r[PB-1:BIT_IDX_W];
          end else begin
            iss_word_nxt = iss_word_r + WW'(1);
          end
        end
        // check side: word read last cycle
        if (tag_valid_r) begin
          if (scan_res.hit) begin
            mem_we         = 1'b1;
            mem_wdata      = mem_rdata | (MAP_WORD'(1) << scan_res.bit_idx);
            res_port_nxt   = hit_port;
            res_status_nxt = STATUS_OK;
            rover_we       = 1'b1;
            rover_wval     = RW'(hit_port) + RW'(1);
            tag_valid_nxt  = 1'b0;
            state_nxt      = S_RESP;
          end else if (tag_last_r) begin
            res_port_nxt   = '0;
            res_status_nxt = STATUS_FAIL;
            rover_we       = 1'b1;
            rover_wval     = '0;
            tag_valid_nxt  = 1'b0;
            state_nxt      = S_RESP;
          end
        end
      end

      S_RESP: begin
        if (res_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      tag_valid_r <= 1'b0;
      iss_done_r  <= 1'b1;
      out_valid_r <= 1'b0;
      port_low_r  <= PORT_LOW_RESET;
      port_high_r <= PORT_HIGH_RESET;
      for (int i = 0; i < NUM_PROTOCOLS; i++) begin
        rover_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      tag_valid_r <= tag_valid_nxt;
      iss_done_r  <= iss_done_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PORT_LOW:  port_low_r  <= cfg_wdata;
          REG_PORT_HIGH: port_high_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (rover_we) begin
        rover_r[rover_widx] <= rover_wval;
      end
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    proto_r      <= proto_nxt;
    alloc_r      <= alloc_nxt;
    mark_bit_r   <= mark_bit_nxt;
    mark_use_r   <= mark_use_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    cur_r        <= cur_nxt;
    cur_m1_r     <= cur_m1_nxt;
    wrap_r       <= wrap_nxt;
    iss_word_r   <= iss_word_nxt;
    iss_pass_r   <= iss_pass_nxt;
    tag_word_r   <= tag_word_nxt;
    tag_pass_r   <= tag_pass_nxt;
    tag_last_r   <= tag_last_nxt;
    res_port_r   <= res_port_nxt;
    res_status_r <= res_status_nxt;
    if (res_load) begin
      out_port_r   <= PORT_W'(res_port_r);
      out_status_r <= res_status_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_port_result = out_port_r;
  assign out_status      = out_status_r;

  // no result may appear while the map is still being cleared
  a_no_out_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !out_valid_r)
    else $error("result presented during map clearing pass");

  // words in flight from the map only exist during a scan
  a_tag_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tag_valid_r |-> state_r == S_SCAN)
    else $error("scan word pending outside scan state");

  // an allocated port lies inside the window captured at the start
  a_alloc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && alloc_r && res_status_r == STATUS_OK) |->
      (res_port_r >= lo_r && res_port_r <= hi_r))
    else $error("allocated port outside configured range");

  // a failed request carries port zero
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == STATUS_FAIL) |-> out_port_r == '0)
    else $error("failed request with nonzero port");

endmodule
